// ===== rtl/rvcore_pkg.sv =====
// Shared codes and helpers for the RV64I integer core.
`default_nettype none
package rvcore_pkg;

   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_OPIMMW = 7'h1B;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_OPW    = 7'h3B;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_FENCE  = 7'h0F;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   localparam logic [31:0] INSN_ECALL  = 32'h0000_0073;
   localparam logic [31:0] INSN_EBREAK = 32'h0010_0073;

   localparam logic [1:0] FAULT_NONE    = 2'd0;
   localparam logic [1:0] FAULT_ALIGN   = 2'd1;
   localparam logic [1:0] FAULT_ILLEGAL = 2'd2;
   localparam logic [1:0] FAULT_SEQ     = 2'd3;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_STORE = 2'd2;

   localparam logic [6:0] F7_ALT = 7'h20;

   typedef logic [63:0] xlen_type;

   function automatic xlen_type sext32(input logic [31:0] v);
      sext32 = {{32{v[31]}}, v};
   endfunction

endpackage
`default_nettype wire

// ===== rtl/rv64i_integer_core_step.sv =====
// Top level of the RV64I integer core: register read, execute and result register.
`default_nettype none
// Each accepted word is either an instruction to run at the current pc (cmd 0) or the
// data for the load issued before (cmd 1); every accepted word yields exactly one result
// word. The core is a two-register pipeline: the register file is read when a word is
// accepted (with a bypass from the write made by the instruction executing in that same
// cycle), and the execute logic between the input register and the result register does
// the ALU, branch, jump and memory request work and writes the register file and pc. One
// word is taken per cycle while the result side is not stalled; a word passes through
// the input register and then the result register, and rsp_stall holds both when the
// result register is full. The
// register file is a 32-entry memory with one valid bit per entry, so reset makes every
// register read as zero at once without a clearing pass. A misaligned fetch or access,
// or an unsupported encoding, halts the core until reset; after that every word returns
// the halted status with no write and no request.
module rv64i_integer_core_step (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_cmd,
   input  wire logic [31:0] req_instr,
   input  wire logic [63:0] req_load_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_wb_valid,
   output logic [4:0]       rsp_wb_reg,
   output logic [63:0]      rsp_wb_value,
   output logic [1:0]       rsp_req_kind,
   output logic [63:0]      rsp_req_address,
   output logic [1:0]       rsp_req_size,
   output logic [63:0]      rsp_store_data,
   output logic [63:0]      rsp_next_pc,
   output logic [1:0]       rsp_fault,
   output logic             rsp_halted
);

   // Pipeline handshake.
   logic s1_vld_ff, s1_vld_in;
   logic out_vld_ff, out_vld_in;
   logic exec_fire, req_fire;

   assign exec_fire = s1_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = s1_vld_ff && !exec_fire;
   assign req_fire  = req_valid && !req_stall;
   assign s1_vld_in = req_fire || (s1_vld_ff && !exec_fire);
   assign out_vld_in = exec_fire || (out_vld_ff && rsp_stall);

   // Input register.
   logic        cmd_ff;
   logic [31:0] ins_ff;
   logic [63:0] ldd_ff;
   rvcore_pkg::xlen_type rs1_ff, rs2_ff;

   // Architectural state.
   rvcore_pkg::xlen_type rf_mem [32];
   logic [31:0] rf_vld_ff;
   rvcore_pkg::xlen_type pc_ff, pc_in;
   logic       ldp_ff, ldp_in;
   logic [4:0] pdst_ff, pdst_in;
   logic [1:0] psz_ff, psz_in;
   logic       psgn_ff, psgn_in;
   logic       halt_ff, halt_in;

   // Execute results.
   logic                 wr_en;
   logic [4:0]           wr_idx;
   rvcore_pkg::xlen_type wr_val;
   logic [1:0]           x_kind, x_size, x_fault;
   rvcore_pkg::xlen_type x_addr, x_sdata;

   // Decode fields.
   logic [6:0] opc, f7;
   logic [4:0] rd, rs1_sel, rs2_sel;
   logic [2:0] f3;
   rvcore_pkg::xlen_type imm_i, imm_s, imm_b, imm_j, imm_u;

   assign opc = ins_ff[6:0];
   assign rd  = ins_ff[11:7];
   assign f3  = ins_ff[14:12];
   assign f7  = ins_ff[31:25];
   assign imm_i = {{52{ins_ff[31]}}, ins_ff[31:20]};
   assign imm_s = {{52{ins_ff[31]}}, ins_ff[31:25], ins_ff[11:7]};
   assign imm_b = {{51{ins_ff[31]}}, ins_ff[31], ins_ff[7], ins_ff[30:25], ins_ff[11:8], 1'b0};
   assign imm_j = {{43{ins_ff[31]}}, ins_ff[31], ins_ff[19:12], ins_ff[20], ins_ff[30:21],
                   1'b0};
   assign imm_u = rvcore_pkg::sext32({ins_ff[31:12], 12'b0});

   assign rs1_sel = req_instr[19:15];
   assign rs2_sel = req_instr[24:20];

   // Register file read at acceptance, with bypass from the write made this cycle.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff <= req_cmd;
         ins_ff <= req_instr;
         ldd_ff <= req_load_data;
         if (wr_en && wr_idx == rs1_sel) begin
            rs1_ff <= wr_val;
         end else if (!rf_vld_ff[rs1_sel]) begin
            rs1_ff <= '0;
         end else begin
            rs1_ff <= rf_mem[rs1_sel];
         end
         if (wr_en && wr_idx == rs2_sel) begin
            rs2_ff <= wr_val;
         end else if (!rf_vld_ff[rs2_sel]) begin
            rs2_ff <= '0;
         end else begin
            rs2_ff <= rf_mem[rs2_sel];
         end
      end
      if (wr_en) begin
         rf_mem[wr_idx] <= wr_val;
      end
   end

   // ALU for the register and immediate forms.
   logic                 immf, wordf, alt, alu_bad;
   logic [5:0]           sh;
   rvcore_pkg::xlen_type op_b, alu_res, addsub;
   logic [31:0]          a32;

   assign immf  = (opc == rvcore_pkg::OPC_OPIMM) || (opc == rvcore_pkg::OPC_OPIMMW);
   assign wordf = (opc == rvcore_pkg::OPC_OPIMMW) || (opc == rvcore_pkg::OPC_OPW);
   assign op_b  = immf ? imm_i : rs2_ff;
   assign sh    = wordf ? {1'b0, op_b[4:0]} : op_b[5:0];
   assign a32   = rs1_ff[31:0];

   always_comb begin
      alu_bad = 1'b0;
      alu_res = '0;
      alt     = (f7 == rvcore_pkg::F7_ALT);
      addsub  = (!immf && alt) ? (rs1_ff - op_b) : (rs1_ff + op_b);
      if (wordf) begin
         case (f3)
            3'd0: begin
               if (!immf && f7 != 7'd0 && !alt) alu_bad = 1'b1;
               alu_res = rvcore_pkg::sext32(addsub[31:0]);
            end
            3'd1: begin
               if (f7 != 7'd0) alu_bad = 1'b1;
               alu_res = rvcore_pkg::sext32(a32 << sh[4:0]);
            end
            3'd5: begin
               if (f7 != 7'd0 && !alt) alu_bad = 1'b1;
               alu_res = alt ? rvcore_pkg::sext32(32'($signed(a32) >>> sh[4:0]))
                             : rvcore_pkg::sext32(a32 >> sh[4:0]);
            end
            default: alu_bad = 1'b1;
         endcase
      end else begin
         if (immf) begin
            if (f3 == 3'd1 && f7[6:1] != 6'd0) alu_bad = 1'b1;
            if (f3 == 3'd5 && f7[6:1] != 6'd0 && f7[6:1] != 6'h10) alu_bad = 1'b1;
            alt = (f7[6:1] == 6'h10);
         end else begin
            if (f7 != 7'd0 && !(alt && (f3 == 3'd0 || f3 == 3'd5))) alu_bad = 1'b1;
         end
         case (f3)
            3'd0: alu_res = addsub;
            3'd1: alu_res = rs1_ff << sh;
            3'd2: alu_res = {63'd0, $signed(rs1_ff) < $signed(op_b)};
            3'd3: alu_res = {63'd0, rs1_ff < op_b};
            3'd4: alu_res = rs1_ff ^ op_b;
            3'd5: alu_res = alt ? 64'($signed(rs1_ff) >>> sh) : (rs1_ff >> sh);
            3'd6: alu_res = rs1_ff | op_b;
            default: alu_res = rs1_ff & op_b;
         endcase
      end
   end

   // Main execute step.
   rvcore_pkg::xlen_type npc, ld_val, maddr, pc4;
   logic                 wb_req, taken, misal, ld_set, go;
   logic [1:0]           msz, fault_c;

   assign pc4 = pc_ff + 64'd4;

   always_comb begin
      case (psz_ff)
         2'd0: ld_val = psgn_ff ? {{56{ldd_ff[7]}}, ldd_ff[7:0]} : {56'd0, ldd_ff[7:0]};
         2'd1: ld_val = psgn_ff ? {{48{ldd_ff[15]}}, ldd_ff[15:0]} : {48'd0, ldd_ff[15:0]};
         2'd2: ld_val = psgn_ff ? rvcore_pkg::sext32(ldd_ff[31:0]) : {32'd0, ldd_ff[31:0]};
         default: ld_val = ldd_ff;
      endcase
   end

   always_comb begin
      fault_c = rvcore_pkg::FAULT_NONE;
      wb_req  = 1'b0;
      wr_idx  = rd;
      wr_val  = '0;
      x_kind  = rvcore_pkg::KIND_NONE;
      x_size  = 2'd0;
      x_addr  = '0;
      x_sdata = '0;
      npc     = pc4;
      taken   = 1'b0;
      ld_set  = 1'b0;
      go      = 1'b0;
      msz     = 2'd0;
      maddr   = rs1_ff + ((opc == rvcore_pkg::OPC_STORE) ? imm_s : imm_i);
      pc_in   = pc_ff;
      ldp_in  = ldp_ff;
      pdst_in = pdst_ff;
      psz_in  = psz_ff;
      psgn_in = psgn_ff;
      halt_in = halt_ff;

      case (opc)
         rvcore_pkg::OPC_LOAD, rvcore_pkg::OPC_STORE: msz = f3[1:0];
         default: msz = 2'd0;
      endcase
      case (msz)
         2'd0: misal = 1'b0;
         2'd1: misal = maddr[0];
         2'd2: misal = |maddr[1:0];
         default: misal = |maddr[2:0];
      endcase

      if (halt_ff) begin
         fault_c = rvcore_pkg::FAULT_NONE;
      end else if (cmd_ff) begin
         if (!ldp_ff) begin
            fault_c = rvcore_pkg::FAULT_SEQ;
         end else begin
            ldp_in = 1'b0;
            wr_idx = pdst_ff;
            wr_val = ld_val;
            wb_req = 1'b1;
         end
      end else if (ldp_ff) begin
         fault_c = rvcore_pkg::FAULT_SEQ;
      end else if (pc_ff[1:0] != 2'd0) begin
         fault_c = rvcore_pkg::FAULT_ALIGN;
      end else begin
         go = 1'b1;
         if (ins_ff[1:0] != 2'b11) begin
            fault_c = rvcore_pkg::FAULT_ILLEGAL;
         end else begin
            case (opc)
               rvcore_pkg::OPC_LOAD: begin
                  if (f3 == 3'd7) fault_c = rvcore_pkg::FAULT_ILLEGAL;
                  else if (misal) fault_c = rvcore_pkg::FAULT_ALIGN;
                  else begin
                     ld_set = 1'b1;
                     x_kind = rvcore_pkg::KIND_LOAD;
                     x_addr = maddr;
                     x_size = f3[1:0];
                  end
               end
               rvcore_pkg::OPC_STORE: begin
                  if (f3[2]) fault_c = rvcore_pkg::FAULT_ILLEGAL;
                  else if (misal) fault_c = rvcore_pkg::FAULT_ALIGN;
                  else begin
                     x_kind  = rvcore_pkg::KIND_STORE;
                     x_addr  = maddr;
                     x_size  = f3[1:0];
                     x_sdata = rs2_ff;
                  end
               end
               rvcore_pkg::OPC_OPIMM, rvcore_pkg::OPC_OPIMMW,
               rvcore_pkg::OPC_OP, rvcore_pkg::OPC_OPW: begin
                  if (alu_bad) fault_c = rvcore_pkg::FAULT_ILLEGAL;
                  else begin
                     wb_req = 1'b1;
                     wr_val = alu_res;
                  end
               end
               rvcore_pkg::OPC_BRANCH: begin
                  case (f3)
                     3'd0: taken = (rs1_ff == rs2_ff);
                     3'd1: taken = (rs1_ff != rs2_ff);
                     3'd4: taken = ($signed(rs1_ff) < $signed(rs2_ff));
                     3'd5: taken = ($signed(rs1_ff) >= $signed(rs2_ff));
                     3'd6: taken = (rs1_ff < rs2_ff);
                     3'd7: taken = (rs1_ff >= rs2_ff);
                     default: fault_c = rvcore_pkg::FAULT_ILLEGAL;
                  endcase
                  if (taken) npc = pc_ff + imm_b;
               end
               rvcore_pkg::OPC_JAL: begin
                  wb_req = 1'b1;
                  wr_val = pc4;
                  npc    = pc_ff + imm_j;
               end
               rvcore_pkg::OPC_JALR: begin
                  if (f3 != 3'd0) fault_c = rvcore_pkg::FAULT_ILLEGAL;
                  else begin
                     npc    = (rs1_ff + imm_i) & ~64'd1;
                     wb_req = 1'b1;
                     wr_val = pc4;
                  end
               end
               rvcore_pkg::OPC_LUI: begin
                  wb_req = 1'b1;
                  wr_val = imm_u;
               end
               rvcore_pkg::OPC_AUIPC: begin
                  wb_req = 1'b1;
                  wr_val = pc_ff + imm_u;
               end
               rvcore_pkg::OPC_FENCE: begin
                  if (f3 != 3'd0) fault_c = rvcore_pkg::FAULT_ILLEGAL;
               end
               rvcore_pkg::OPC_SYSTEM: begin
                  if (ins_ff != rvcore_pkg::INSN_ECALL && ins_ff != rvcore_pkg::INSN_EBREAK)
                     fault_c = rvcore_pkg::FAULT_ILLEGAL;
               end
               default: fault_c = rvcore_pkg::FAULT_ILLEGAL;
            endcase
         end
         if (fault_c == rvcore_pkg::FAULT_NONE) begin
            pc_in = npc;
            if (ld_set) begin
               ldp_in  = 1'b1;
               pdst_in = rd;
               psz_in  = f3[1:0];
               psgn_in = !f3[2];
            end
         end
      end

      // A halting fault cancels any write and request of this step.
      if (fault_c == rvcore_pkg::FAULT_ALIGN || fault_c == rvcore_pkg::FAULT_ILLEGAL) begin
         halt_in = 1'b1;
         ldp_in  = 1'b0;
         wb_req  = 1'b0;
         x_kind  = rvcore_pkg::KIND_NONE;
         x_addr  = '0;
         x_size  = 2'd0;
         x_sdata = '0;
      end
      if (!go) begin
         ld_set = 1'b0;
      end
      x_fault = fault_c;
      wr_en   = exec_fire && wb_req && (wr_idx != 5'd0);
   end

   // Control and architectural state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         rf_vld_ff  <= '0;
         pc_ff      <= '0;
         ldp_ff     <= 1'b0;
         pdst_ff    <= '0;
         psz_ff     <= '0;
         psgn_ff    <= 1'b0;
         halt_ff    <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
         if (wr_en) rf_vld_ff[wr_idx] <= 1'b1;
         if (exec_fire) begin
            pc_ff   <= pc_in;
            ldp_ff  <= ldp_in;
            pdst_ff <= pdst_in;
            psz_ff  <= psz_in;
            psgn_ff <= psgn_in;
            halt_ff <= halt_in;
         end
      end
   end

   // Result register.
   logic        o_wbv_ff;
   logic [4:0]  o_wbr_ff;
   logic [63:0] o_wbval_ff, o_addr_ff, o_sdata_ff, o_npc_ff;
   logic [1:0]  o_kind_ff, o_size_ff, o_fault_ff;
   logic        o_halt_ff;

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         o_wbv_ff   <= wr_en;
         o_wbr_ff   <= wr_en ? wr_idx : 5'd0;
         o_wbval_ff <= wr_en ? wr_val : 64'd0;
         o_kind_ff  <= x_kind;
         o_addr_ff  <= x_addr;
         o_size_ff  <= x_size;
         o_sdata_ff <= x_sdata;
         o_npc_ff   <= pc_in;
         o_fault_ff <= x_fault;
         o_halt_ff  <= halt_in;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_wb_valid    = o_wbv_ff;
   assign rsp_wb_reg      = o_wbr_ff;
   assign rsp_wb_value    = o_wbval_ff;
   assign rsp_req_kind    = o_kind_ff;
   assign rsp_req_address = o_addr_ff;
   assign rsp_req_size    = o_size_ff;
   assign rsp_store_data  = o_sdata_ff;
   assign rsp_next_pc     = o_npc_ff;
   assign rsp_fault       = o_fault_ff;
   assign rsp_halted      = o_halt_ff;

   // Register zero is never reported as written.
   a_no_x0_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wb_valid |-> rsp_wb_reg != 5'd0)
      else $error("write to register zero reported");

   // A halting fault always comes with the halted flag and no side effects.
   a_fault_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_fault == rvcore_pkg::FAULT_ALIGN ||
                    rsp_fault == rvcore_pkg::FAULT_ILLEGAL)
      |-> rsp_halted && !rsp_wb_valid && rsp_req_kind == rvcore_pkg::KIND_NONE)
      else $error("fault without halt or with side effects");

   // Once halted, the core stays halted until reset.
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt flag cleared without reset");

   // The register file is written only by an executing word.
   a_write_fire: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> exec_fire && s1_vld_ff)
      else $error("register write without execute");

   // A request is never issued while a load is still outstanding.
   a_no_req_pending: assert property (@(posedge clock) disable iff (reset)
      exec_fire && ldp_ff |-> x_kind == rvcore_pkg::KIND_NONE)
      else $error("memory request while a load is pending");

endmodule
`default_nettype wire

// ===== dv/tb_rv64i_integer_core_step.sv =====
// Self-checking testbench for the RV64I integer core step block.
`default_nettype none

// One result word of the core, field by field in port order.
typedef struct packed {
   logic        wb_valid;
   logic [4:0]  wb_reg;
   logic [63:0] wb_value;
   logic [1:0]  req_kind;
   logic [63:0] req_address;
   logic [1:0]  req_size;
   logic [63:0] store_data;
   logic [63:0] next_pc;
   logic [1:0]  fault;
   logic        halted;
} core_result_type;

// Holds the architectural state of the core and the queue of results it should produce.
class core_scoreboard;
   logic [63:0]     regs [32];
   logic [63:0]     pc;
   logic            load_waiting;
   logic [4:0]      load_dest;
   logic [1:0]      load_size;
   logic            load_signed;
   logic            stopped;
   core_result_type pending_results [$];
   int              error_count;

   function new();
      foreach (regs[i]) regs[i] = '0;
      pc = '0;
      load_waiting = 0;
      load_dest = '0;
      load_size = '0;
      load_signed = 0;
      stopped = 0;
      error_count = 0;
   endfunction

   static function logic [63:0] sign_extend(logic [63:0] v, int bits);
      logic [63:0] mask;
      mask = (bits >= 64) ? '1 : ((64'd1 << bits) - 1);
      v &= mask;
      if (bits < 64 && v[bits-1]) v |= ~mask;
      return v;
   endfunction

   static function logic [63:0] word_extend(logic [63:0] v);
      return {{32{v[31]}}, v[31:0]};
   endfunction

   function void write_reg(ref core_result_type r, input logic [4:0] rd,
                           input logic [63:0] v);
      if (rd != 0) begin
         regs[rd] = v;
         r.wb_valid = 1;
         r.wb_reg = rd;
         r.wb_value = v;
      end
   endfunction

   // Integer ALU for the register and immediate forms; returns the fault code.
   function logic [1:0] compute_alu(logic [2:0] f3, logic [6:0] f7, bit immf, bit word,
                                    logic [63:0] a, logic [63:0] b, output logic [63:0] res);
      int unsigned sh;
      bit alt;
      logic [31:0] w;
      sh = word ? b[4:0] : b[5:0];
      alt = (f7 == rvcore_pkg::F7_ALT);
      res = '0;
      if (word) begin
         case (f3)
            3'd0: begin
               if (!immf && f7 != 0 && !alt) return rvcore_pkg::FAULT_ILLEGAL;
               res = word_extend((!immf && alt) ? a - b : a + b);
            end
            3'd1: begin
               if (f7 != 0) return rvcore_pkg::FAULT_ILLEGAL;
               w = a[31:0] << sh;
               res = word_extend({32'd0, w});
            end
            3'd5: begin
               if (f7 != 0 && !alt) return rvcore_pkg::FAULT_ILLEGAL;
               if (alt) w = $signed(a[31:0]) >>> sh;
               else w = a[31:0] >> sh;
               res = word_extend({32'd0, w});
            end
            default: return rvcore_pkg::FAULT_ILLEGAL;
         endcase
         return rvcore_pkg::FAULT_NONE;
      end
      if (immf) begin
         if (f3 == 1 && f7[6:1] != 0) return rvcore_pkg::FAULT_ILLEGAL;
         if (f3 == 5 && f7[6:1] != 0 && f7[6:1] != 6'h10) return rvcore_pkg::FAULT_ILLEGAL;
         alt = (f7[6:1] == 6'h10);
      end else if (f7 != 0 && !(alt && (f3 == 0 || f3 == 5))) begin
         return rvcore_pkg::FAULT_ILLEGAL;
      end
      case (f3)
         3'd0: res = (!immf && alt) ? a - b : a + b;
         3'd1: res = a << sh;
         3'd2: res = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
         3'd3: res = (a < b) ? 64'd1 : 64'd0;
         3'd4: res = a ^ b;
         3'd5: res = alt ? 64'($signed(a) >>> sh) : a >> sh;
         3'd6: res = a | b;
         default: res = a & b;
      endcase
      return rvcore_pkg::FAULT_NONE;
   endfunction

   // Notes one accepted input word and queues the result the core should return.
   function void note_input(logic cmd, logic [31:0] ins, logic [63:0] data);
      core_result_type r;
      logic [6:0]  opc;
      logic [4:0]  rd, rs1, rs2;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [63:0] a, b, imm, res, addr, npc, v;
      logic [1:0]  flt;
      bit taken;
      int bits;
      opc = ins[6:0]; rd = ins[11:7]; f3 = ins[14:12];
      rs1 = ins[19:15]; rs2 = ins[24:20]; f7 = ins[31:25];
      r = '0;
      flt = rvcore_pkg::FAULT_NONE;
      regs[0] = '0;
      if (stopped) begin
      end else if (cmd) begin
         if (!load_waiting) flt = rvcore_pkg::FAULT_SEQ;
         else begin
            bits = 8 << load_size;
            v = (bits >= 64) ? data : data & ((64'd1 << bits) - 1);
            if (load_signed) v = sign_extend(v, bits);
            load_waiting = 0;
            write_reg(r, load_dest, v);
         end
      end else if (load_waiting) begin
         flt = rvcore_pkg::FAULT_SEQ;
      end else if (pc[1:0] != 0) begin
         flt = rvcore_pkg::FAULT_ALIGN;
      end else begin
         npc = pc + 4;
         a = regs[rs1];
         b = regs[rs2];
         if (ins[1:0] != 2'b11) flt = rvcore_pkg::FAULT_ILLEGAL;
         else case (opc)
            rvcore_pkg::OPC_LOAD: begin
               addr = a + sign_extend(ins[31:20], 12);
               if (f3 == 7) flt = rvcore_pkg::FAULT_ILLEGAL;
               else if ((addr & ((64'd1 << f3[1:0]) - 1)) != 0)
                  flt = rvcore_pkg::FAULT_ALIGN;
               else begin
                  load_waiting = 1;
                  load_dest = rd;
                  load_size = f3[1:0];
                  load_signed = !f3[2];
                  r.req_kind = rvcore_pkg::KIND_LOAD;
                  r.req_address = addr;
                  r.req_size = f3[1:0];
               end
            end
            rvcore_pkg::OPC_STORE: begin
               addr = a + sign_extend({ins[31:25], ins[11:7]}, 12);
               if (f3 > 3) flt = rvcore_pkg::FAULT_ILLEGAL;
               else if ((addr & ((64'd1 << f3[1:0]) - 1)) != 0)
                  flt = rvcore_pkg::FAULT_ALIGN;
               else begin
                  r.req_kind = rvcore_pkg::KIND_STORE;
                  r.req_address = addr;
                  r.req_size = f3[1:0];
                  r.store_data = b;
               end
            end
            rvcore_pkg::OPC_OPIMM, rvcore_pkg::OPC_OPIMMW,
            rvcore_pkg::OPC_OP, rvcore_pkg::OPC_OPW: begin
               bit immf, word;
               immf = (opc == rvcore_pkg::OPC_OPIMM || opc == rvcore_pkg::OPC_OPIMMW);
               word = (opc == rvcore_pkg::OPC_OPIMMW || opc == rvcore_pkg::OPC_OPW);
               if (immf) b = sign_extend(ins[31:20], 12);
               flt = compute_alu(f3, f7, immf, word, a, b, res);
               if (flt == rvcore_pkg::FAULT_NONE) write_reg(r, rd, res);
            end
            rvcore_pkg::OPC_BRANCH: begin
               imm = sign_extend({ins[31], ins[7], ins[30:25], ins[11:8], 1'b0}, 13);
               case (f3)
                  3'd0: taken = (a == b);
                  3'd1: taken = (a != b);
                  3'd4: taken = ($signed(a) < $signed(b));
                  3'd5: taken = ($signed(a) >= $signed(b));
                  3'd6: taken = (a < b);
                  3'd7: taken = (a >= b);
                  default: begin taken = 0; flt = rvcore_pkg::FAULT_ILLEGAL; end
               endcase
               if (taken) npc = pc + imm;
            end
            rvcore_pkg::OPC_JAL: begin
               imm = sign_extend({ins[31], ins[19:12], ins[20], ins[30:21], 1'b0}, 21);
               write_reg(r, rd, pc + 4);
               npc = pc + imm;
            end
            rvcore_pkg::OPC_JALR: begin
               if (f3 != 0) flt = rvcore_pkg::FAULT_ILLEGAL;
               else begin
                  npc = (a + sign_extend(ins[31:20], 12)) & ~64'd1;
                  write_reg(r, rd, pc + 4);
               end
            end
            rvcore_pkg::OPC_LUI: write_reg(r, rd, word_extend({32'd0, ins[31:12], 12'd0}));
            rvcore_pkg::OPC_AUIPC:
               write_reg(r, rd, pc + word_extend({32'd0, ins[31:12], 12'd0}));
            rvcore_pkg::OPC_FENCE: if (f3 != 0) flt = rvcore_pkg::FAULT_ILLEGAL;
            rvcore_pkg::OPC_SYSTEM:
               if (ins != rvcore_pkg::INSN_ECALL && ins != rvcore_pkg::INSN_EBREAK)
                  flt = rvcore_pkg::FAULT_ILLEGAL;
            default: flt = rvcore_pkg::FAULT_ILLEGAL;
         endcase
         if (flt == rvcore_pkg::FAULT_NONE) pc = npc;
      end
      if (flt == rvcore_pkg::FAULT_ALIGN || flt == rvcore_pkg::FAULT_ILLEGAL) begin
         stopped = 1;
         load_waiting = 0;
         r = '0;
      end
      regs[0] = '0;
      r.next_pc = pc;
      r.fault = flt;
      r.halted = stopped;
      pending_results.push_back(r);
   endfunction

   // Compares one accepted result word with the oldest queued expectation.
   function void check_result(core_result_type got);
      core_result_type want;
      if (pending_results.size() == 0) begin
         $display("%0t: result with nothing expected: %p", $time, got);
         error_count++;
         return;
      end
      want = pending_results.pop_front();
      if (got.wb_valid !== want.wb_valid)
         $display("%0t: wb_valid expected %0d got %0d", $time, want.wb_valid, got.wb_valid);
      if (got.wb_reg !== want.wb_reg)
         $display("%0t: wb_reg expected %0d got %0d", $time, want.wb_reg, got.wb_reg);
      if (got.wb_value !== want.wb_value)
         $display("%0t: wb_value expected %h got %h", $time, want.wb_value, got.wb_value);
      if (got.req_kind !== want.req_kind)
         $display("%0t: req_kind expected %0d got %0d", $time, want.req_kind, got.req_kind);
      if (got.req_address !== want.req_address)
         $display("%0t: req_address expected %h got %h", $time, want.req_address,
                  got.req_address);
      if (got.req_size !== want.req_size)
         $display("%0t: req_size expected %0d got %0d", $time, want.req_size, got.req_size);
      if (got.store_data !== want.store_data)
         $display("%0t: store_data expected %h got %h", $time, want.store_data,
                  got.store_data);
      if (got.next_pc !== want.next_pc)
         $display("%0t: next_pc expected %h got %h", $time, want.next_pc, got.next_pc);
      if (got.fault !== want.fault)
         $display("%0t: fault expected %0d got %0d", $time, want.fault, got.fault);
      if (got.halted !== want.halted)
         $display("%0t: halted expected %0d got %0d", $time, want.halted, got.halted);
      if (got !== want) error_count++;
   endfunction
endclass

module tb_rv64i_integer_core_step;

   // Stimulus runs as a directed part and then a random program, with no reset between; since reset is
   // asserted only once, a halt would end all useful work, so faulting words are kept for
   // the very end of the run, after the random program has finished.
   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_cmd = 0;
   logic [31:0] req_instr = '0;
   logic [63:0] req_load_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1;
   logic        rsp_wb_valid;
   logic [4:0]  rsp_wb_reg;
   logic [63:0] rsp_wb_value;
   logic [1:0]  rsp_req_kind;
   logic [63:0] rsp_req_address;
   logic [1:0]  rsp_req_size;
   logic [63:0] rsp_store_data;
   logic [63:0] rsp_next_pc;
   logic [1:0]  rsp_fault;
   logic        rsp_halted;

   rv64i_integer_core_step dut (.*);

   always #10 clock = ~clock;

   core_scoreboard board = new();
   int  cycle_count = 0;
   bit  stimulus_done = 0;
   bit  hold_off = 0;

   // The model of the core runs ahead of the block: it is updated as each word is accepted,
   // so the random generator can read architectural state (pc, pending load) to shape
   // programs that stay well formed.

   // Offers one word and waits until the block accepts it. Valid stays high into the next
   // word when there is no idle gap.
   task automatic send_word(logic cmd, logic [31:0] ins, logic [63:0] data);
      int gap;
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_instr <= ins;
      req_load_data <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_input(cmd, ins, data);
   endtask

   // Runs one instruction; a load is answered at once with random data.
   task automatic run_insn(logic [31:0] ins);
      send_word(1'b0, ins, {$urandom, $urandom});
      if (board.load_waiting) send_word(1'b1, $urandom, {$urandom, $urandom});
   endtask

   function automatic logic [31:0] enc_i(logic [6:0] opc, logic [2:0] f3, logic [4:0] rd,
                                         logic [4:0] rs1, logic [11:0] imm);
      return {imm, rs1, f3, rd, opc};
   endfunction

   function automatic logic [31:0] enc_r(logic [6:0] opc, logic [2:0] f3, logic [6:0] f7,
                                         logic [4:0] rd, logic [4:0] rs1, logic [4:0] rs2);
      return {f7, rs2, rs1, f3, rd, opc};
   endfunction

   function automatic logic [31:0] enc_s(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                         logic [11:0] imm);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], rvcore_pkg::OPC_STORE};
   endfunction

   function automatic logic [31:0] enc_b(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                         logic [12:0] imm);
      return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], rvcore_pkg::OPC_BRANCH};
   endfunction

   // Picks a random base register and an offset that make rs1 + imm aligned for a size.
   function automatic logic [4:0] pick_base(int sz, output logic [11:0] imm);
      logic [4:0] r;
      r = 5'($urandom_range(0, 31));
      imm = 12'($urandom);
      imm = imm & ~((12'd1 << sz) - 12'd1);
      imm = imm - (board.regs[r][11:0] & ((12'd1 << sz) - 12'd1));
      return r;
   endfunction

   // Draws one legal instruction with random content; control flow keeps the pc aligned.
   function automatic logic [31:0] random_legal();
      logic [2:0]  f3;
      logic [4:0]  rd, rs1, rs2;
      logic [11:0] imm;
      logic [6:0]  f7;
      logic [12:0] bimm;
      logic [31:0] ins;
      rd = 5'($urandom); rs1 = 5'($urandom); rs2 = 5'($urandom); f3 = 3'($urandom);
      imm = 12'($urandom);
      case ($urandom_range(0, 13))
         0, 1: begin
            f7 = ($urandom_range(0, 1)) ? rvcore_pkg::F7_ALT : 7'd0;
            if (f3 != 0 && f3 != 5) f7 = 0;
            ins = enc_r(rvcore_pkg::OPC_OP, f3, f7, rd, rs1, rs2);
         end
         2, 3: begin
            if (f3 == 1) imm[11:6] = 0;
            if (f3 == 5) imm[11:6] = $urandom_range(0, 1) ? 6'h10 : 6'h00;
            ins = enc_i(rvcore_pkg::OPC_OPIMM, f3, rd, rs1, imm);
         end
         4: begin
            f3 = $urandom_range(0, 1) ? 3'd5 : 3'd1;
            if ($urandom_range(0, 2) == 0) f3 = 0;
            f7 = (f3 == 5 && $urandom_range(0, 1)) ? rvcore_pkg::F7_ALT : 7'd0;
            if (f3 == 0) imm = 12'($urandom);
            else imm = {f7, imm[4:0]};
            ins = enc_i(rvcore_pkg::OPC_OPIMMW, f3, rd, rs1, imm);
         end
         5: begin
            f3 = $urandom_range(0, 1) ? 3'd5 : 3'd1;
            if ($urandom_range(0, 2) == 0) f3 = 0;
            f7 = (f3 != 1 && $urandom_range(0, 1)) ? rvcore_pkg::F7_ALT : 7'd0;
            ins = enc_r(rvcore_pkg::OPC_OPW, f3, f7, rd, rs1, rs2);
         end
         6: ins = {20'($urandom), rd, rvcore_pkg::OPC_LUI};
         7: ins = {20'($urandom), rd, rvcore_pkg::OPC_AUIPC};
         8, 9: begin
            f3 = 3'($urandom_range(0, 6));
            rs1 = pick_base(f3[1:0], imm);
            ins = enc_i(rvcore_pkg::OPC_LOAD, f3, rd, rs1, imm);
         end
         10: begin
            f3 = 3'($urandom_range(0, 3));
            rs1 = pick_base(f3, imm);
            ins = enc_s(f3, rs1, rs2, imm);
         end
         11: begin
            f3 = 3'($urandom_range(0, 5));
            f3 = (f3 < 3'd2) ? f3 : f3 + 3'd2;
            bimm = ($urandom_range(0, 1) ? 13'h1FC0 : 13'h0000) | 13'($urandom & 32'h3C);
            ins = enc_b(f3, rs1, rs2, bimm);
         end
         12: ins = {1'b0, 10'($urandom_range(0, 16) << 1), 1'b0, 8'd0, rd,
                    rvcore_pkg::OPC_JAL};
         default: begin
            // Jump through a register with an offset chosen so that the target is aligned.
            rs1 = pick_base(2, imm);
            ins = enc_i(rvcore_pkg::OPC_JALR, 3'd0, rd, rs1, imm);
         end
      endcase
      return ins;
   endfunction

   // Receiver: random stalls per word, plus a long hold-off requested by the sender side.
   initial begin : receiver
      int gap;
      core_result_type got;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1;
            repeat (60) @(posedge clock);
            hold_off = 0;
         end
         gap = $urandom_range(0, 5);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap != 0) begin
            rsp_stall <= 1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 0;
         @(posedge clock);
         while (!rsp_valid || rsp_stall) @(posedge clock);
         got = {rsp_wb_valid, rsp_wb_reg, rsp_wb_value, rsp_req_kind, rsp_req_address,
                rsp_req_size, rsp_store_data, rsp_next_pc, rsp_fault, rsp_halted};
         board.check_result(got);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic [31:0] ins;
      int          n;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: register extremes, a range of operations, sequencing errors and x0.
      run_insn({20'h80000, 5'd1, rvcore_pkg::OPC_LUI});      // x1 = 0xFFFF_FFFF_8000_0000
      run_insn(enc_i(rvcore_pkg::OPC_OPIMM, 3'd0, 5'd2, 5'd0, 12'hFFF));  // x2 = -1
      run_insn(enc_i(rvcore_pkg::OPC_OPIMM, 3'd1, 5'd3, 5'd2, 12'h03F));  // x3 = 1 << 63
      run_insn(enc_i(rvcore_pkg::OPC_OPIMM, 3'd5, 5'd4, 5'd3, 12'h43F));  // sra by 63
      run_insn(enc_r(rvcore_pkg::OPC_OP, 3'd0, rvcore_pkg::F7_ALT, 5'd5, 5'd0, 5'd3));
      run_insn(enc_r(rvcore_pkg::OPC_OP, 3'd2, 7'd0, 5'd6, 5'd3, 5'd2));
      run_insn(enc_r(rvcore_pkg::OPC_OP, 3'd3, 7'd0, 5'd7, 5'd3, 5'd2));
      run_insn(enc_r(rvcore_pkg::OPC_OPW, 3'd5, rvcore_pkg::F7_ALT, 5'd8, 5'd1, 5'd2));
      run_insn(enc_i(rvcore_pkg::OPC_OPIMMW, 3'd1, 5'd9, 5'd2, 12'h01F));
      run_insn(enc_i(rvcore_pkg::OPC_OPIMM, 3'd0, 5'd0, 5'd2, 12'h123)); // x0 write dropped
      run_insn({20'hFFFFF, 5'd10, rvcore_pkg::OPC_AUIPC});
      run_insn(enc_s(3'd3, 5'd0, 5'd2, 12'h008));
      run_insn(enc_i(rvcore_pkg::OPC_LOAD, 3'd0, 5'd11, 5'd0, 12'h001)); // signed byte load
      run_insn(enc_i(rvcore_pkg::OPC_LOAD, 3'd6, 5'd0, 5'd0, 12'h004));  // x0 load requests
      send_word(1'b1, '1, '1);                               // data with no load pending
      send_word(1'b0, enc_i(rvcore_pkg::OPC_LOAD, 3'd3, 5'd12, 5'd0, 12'h010), '0);
      send_word(1'b0, enc_i(rvcore_pkg::OPC_OPIMM, 3'd0, 5'd1, 5'd0, 12'h001), '0);
      send_word(1'b1, '0, 64'h8000_0000_0000_0000);
      run_insn(enc_b(3'd1, 5'd2, 5'd0, 13'h0008));          // taken branch
      run_insn(enc_b(3'd7, 5'd0, 5'd2, 13'h1FF8));          // not taken
      run_insn({1'b0, 10'd4, 1'b0, 8'd0, 5'd1, rvcore_pkg::OPC_JAL});
      run_insn(32'h0100_000F);                               // fence
      run_insn(rvcore_pkg::INSN_ECALL);
      run_insn(rvcore_pkg::INSN_EBREAK);

      // Random programs; a long receiver hold-off lands partway through so the block fills.
      n = 0;
      while (n < 600) begin
         if (n == 200) hold_off = 1;
         if ($urandom_range(0, 40) == 0) begin
            // Sequencing noise that the core reports but survives.
            send_word(1'b1, $urandom, {$urandom, $urandom});
         end else begin
            ins = random_legal();
            run_insn(ins);
         end
         n++;
      end

      // Faulting words last, since a halt lasts until reset.
      case ($urandom_range(0, 3))
         0: send_word(1'b0, 32'hFFFF_FFFC, '0);                 // low bits not 11
         1: send_word(1'b0, enc_r(rvcore_pkg::OPC_OP, 3'd1, rvcore_pkg::F7_ALT, 5'd1, 5'd2,
                                  5'd3), '0);
         2: send_word(1'b0, 32'h0000_100F, '0);                 // fence.i
         default: send_word(1'b0, enc_s(3'd3, 5'd0, 5'd2, 12'h004), '0);
      endcase
      send_word(1'b0, 32'h0000_0010, '0);                     // low bits not 11
      send_word(1'b0, rvcore_pkg::INSN_ECALL | 32'h0000_1000, '0); // system, halted
      run_insn({20'h00002, 5'd0, rvcore_pkg::OPC_JAL});
      send_word(1'b1, '1, '1);
      req_valid <= 0;
      stimulus_done = 1;
   end

   initial begin : finisher
      wait (stimulus_done);
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.error_count == 0 && board.pending_results.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/rvcore_pkg.sv
rtl/rv64i_integer_core_step.sv
dv/tb_rv64i_integer_core_step.sv
